// File: hw/rtl/lhs_pkg.sv
// lhs_pkg: shared constants for the linear hash set insert block
// field widths, status codes, parameter defaults; no dependencies
`default_nettype none

package lhs_pkg;

  localparam int KEY_W    = 32;
  localparam int STATUS_W = 2;
  localparam int CFG_W    = 7;

  localparam int MAX_BUCKETS_DEF        = 64;
  localparam int ENTRIES_PER_BUCKET_DEF = 64;

  localparam logic [CFG_W-1:0] PAGE_CAP_RESET = CFG_W'(30);

  localparam logic [STATUS_W-1:0] ST_NEW  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

endpackage

`default_nettype wire

// File: hw/rtl/lhs_if.sv
// lhs_in_if / lhs_out_if: valid/ready channels for keys and results
// depends on lhs_pkg
`default_nettype none

interface lhs_in_if
  import lhs_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface

interface lhs_out_if
  import lhs_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [KEY_W-1:0]    key_echo;

  modport source (output valid, output status, output key_echo, input ready);
  modport sink   (input valid, input status, input key_echo, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/linear_hash_set_insert.sv
// linear_hash_set_insert: duplicate filter on a linear-hashing bucket store
// depends on lhs_pkg and the channel interfaces in lhs_if.sv
//
// Usage: keys enter on in_if (valid/ready), one result per key leaves on
// out_if with a status (new, duplicate, bucket full) and the key echoed.
// page_capacity is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce this.
// One key is handled at a time. The key's bucket is scanned one entry per
// cycle, since the key store has one read port. When the load threshold
// trips, a split follows: the entries of the bucket being split are
// rehashed one per cycle through the same port.
// After reset the block clears the fill counts of the two initial buckets
// in S_INIT0 and S_INIT1; in_if.ready stays low during that time.
// Results sit in an output register; the next key is accepted while a result
// waits, and a finished result holds the sequencer only if the previous one
// has still not been taken.
`default_nettype none

module linear_hash_set_insert
  import lhs_pkg::*;
#(
  parameter int MAX_BUCKETS        = MAX_BUCKETS_DEF,
  parameter int ENTRIES_PER_BUCKET = ENTRIES_PER_BUCKET_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  lhs_in_if.sink                in_if,
  lhs_out_if.source             out_if,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam int DEPTH = MAX_BUCKETS * ENTRIES_PER_BUCKET;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BW    = $clog2(MAX_BUCKETS);
  localparam int HW    = BW + 1;
  localparam int FW    = $clog2(ENTRIES_PER_BUCKET + 1);
  localparam int TW    = $clog2(DEPTH + 1);
  localparam int PW    = HW + CFG_W;
  localparam int CMW   = (TW + 2 > PW + 2) ? TW + 2 : PW + 2;

  localparam logic [3:0] S_INIT0 = 4'd0;
  localparam logic [3:0] S_INIT1 = 4'd1;
  localparam logic [3:0] S_IDLE  = 4'd2;
  localparam logic [3:0] S_FRD   = 4'd3;
  localparam logic [3:0] S_FGET  = 4'd4;
  localparam logic [3:0] S_SCAN  = 4'd5;
  localparam logic [3:0] S_DEC   = 4'd6;
  localparam logic [3:0] S_THR   = 4'd7;
  localparam logic [3:0] S_SFRD  = 4'd8;
  localparam logic [3:0] S_SFGET = 4'd9;
  localparam logic [3:0] S_SMOV  = 4'd10;
  localparam logic [3:0] S_SEND  = 4'd11;
  localparam logic [3:0] S_SEND2 = 4'd12;
  localparam logic [3:0] S_DONE  = 4'd13;

  logic [KEY_W-1:0] store_mem [DEPTH];
  logic [FW-1:0]    fill_mem  [MAX_BUCKETS];
  logic [KEY_W-1:0] store_q;
  logic [FW-1:0]    fill_q;

  logic [3:0]          state_r, state_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [BW-1:0]       bucket_r, bucket_nxt;
  logic [FW-1:0]       n_r, n_nxt;
  logic [FW-1:0]       i_r, i_nxt;
  logic [FW-1:0]       keep_r, keep_nxt;
  logic [FW-1:0]       newf_r, newf_nxt;
  logic [PW-1:0]       prod_r, prod_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [HW-1:0]       count_r, count_nxt;
  logic [HW-1:0]       mod_r, mod_nxt;
  logic [BW-1:0]       sp_r, sp_nxt;
  logic [TW-1:0]       total_r, total_nxt;
  logic [CFG_W-1:0]    pcap_r, pcap_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [KEY_W-1:0]    out_key_r, out_key_nxt;

  logic             st_we, fill_we;
  logic [AW-1:0]    st_waddr, st_raddr;
  logic [KEY_W-1:0] st_wdata;
  logic [BW-1:0]    fill_waddr, fill_raddr;
  logic [FW-1:0]    fill_wdata;

  logic [BW-1:0]  dst;
  logic [BW-1:0]  new_bkt;
  logic [CMW-1:0] lhs_cmp, rhs_cmp;
  logic           out_take;

  function automatic logic [AW-1:0] entry_addr(input logic [BW-1:0] b,
                                               input logic [FW-1:0] e);
    logic [AW+FW-1:0] a;
    a = (AW+FW)'(b) * (AW+FW)'(ENTRIES_PER_BUCKET) + (AW+FW)'(e);
    return a[AW-1:0];
  endfunction

  function automatic logic [BW-1:0] home_bucket(input logic [KEY_W-1:0] k,
                                                input logic [HW-1:0] m,
                                                input logic [HW-1:0] cnt);
    logic [HW-1:0] b;
    b = k[HW-1:0] & (m - HW'(1));
    if (b >= cnt) begin
      b = b - (m >> 1);
    end
    if (b >= HW'(MAX_BUCKETS)) begin
      b = '0;
    end
    return b[BW-1:0];
  endfunction

  assign in_if.ready     = (state_r == S_IDLE);
  assign out_if.valid    = out_valid_r;
  assign out_if.status   = out_status_r;
  assign out_if.key_echo = out_key_r;
  assign out_take        = out_valid_r && out_if.ready;

  assign dst     = home_bucket(store_q, mod_r, count_r);
  assign new_bkt = BW'(count_r - HW'(1));
  assign lhs_cmp = CMW'({total_r, 2'b00});
  assign rhs_cmp = CMW'(prod_r) + CMW'({prod_r, 1'b0});

  always_comb begin
    state_nxt      = state_r;
    key_nxt        = key_r;
    bucket_nxt     = bucket_r;
    n_nxt          = n_r;
    i_nxt          = i_r;
    keep_nxt       = keep_r;
    newf_nxt       = newf_r;
    prod_nxt       = prod_r;
    status_nxt     = status_r;
    count_nxt      = count_r;
    mod_nxt        = mod_r;
    sp_nxt         = sp_r;
    total_nxt      = total_r;
    pcap_nxt       = cfg_we ? cfg_wdata : pcap_r;
    out_valid_nxt  = out_take ? 1'b0 : out_valid_r;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    st_we          = 1'b0;
    st_waddr       = entry_addr(bucket_r, n_r);
    st_wdata       = key_r;
    st_raddr       = entry_addr(bucket_r, i_r + FW'(1));
    fill_we        = 1'b0;
    fill_waddr     = bucket_r;
    fill_wdata     = n_r + FW'(1);
    fill_raddr     = bucket_r;

    unique case (state_r)
      S_INIT0: begin
        fill_we    = 1'b1;
        fill_waddr = '0;
        fill_wdata = '0;
        state_nxt  = S_INIT1;
      end
      S_INIT1: begin
        fill_we    = 1'b1;
        fill_waddr = BW'(1);
        fill_wdata = '0;
        state_nxt  = S_IDLE;
      end
      S_IDLE: begin
        if (in_if.valid) begin
          key_nxt    = in_if.key;
          bucket_nxt = home_bucket(in_if.key, mod_r, count_r);
          state_nxt  = S_FRD;
        end
      end
      S_FRD: begin
        state_nxt = S_FGET;
      end
      S_FGET: begin
        n_nxt    = fill_q;
        i_nxt    = '0;
        st_raddr = entry_addr(bucket_r, '0);
        state_nxt = (fill_q == '0) ? S_DEC : S_SCAN;
      end
      S_SCAN: begin
        // store_q holds entry i_r, the read of i_r + 1 is already in flight
        if (store_q == key_r) begin
          status_nxt = ST_DUP;
          state_nxt  = S_DONE;
        end else if (i_r + FW'(1) == n_r) begin
          state_nxt = S_DEC;
        end else begin
          i_nxt = i_r + FW'(1);
        end
      end
      S_DEC: begin
        if (n_r == FW'(ENTRIES_PER_BUCKET)) begin
          status_nxt = ST_FULL;
          state_nxt  = S_DONE;
        end else begin
          st_we      = 1'b1;
          fill_we    = 1'b1;
          total_nxt  = total_r + TW'(1);
          prod_nxt   = PW'(count_r) * PW'(pcap_r);
          status_nxt = ST_NEW;
          state_nxt  = S_THR;
        end
      end
      S_THR: begin
        if (lhs_cmp > rhs_cmp && count_r < HW'(MAX_BUCKETS)) begin
          count_nxt = count_r + HW'(1);
          if (mod_r < count_r + HW'(1)) begin
            mod_nxt = {mod_r[HW-2:0], 1'b0};
          end
          state_nxt = S_SFRD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_SFRD: begin
        fill_raddr = sp_r;
        state_nxt  = S_SFGET;
      end
      S_SFGET: begin
        n_nxt     = fill_q;
        i_nxt     = '0;
        keep_nxt  = '0;
        newf_nxt  = '0;
        st_raddr  = entry_addr(sp_r, '0);
        state_nxt = (fill_q == '0) ? S_SEND : S_SMOV;
      end
      S_SMOV: begin
        // compact kept keys in place, moved keys go to the new bucket
        st_we    = 1'b1;
        st_wdata = store_q;
        st_raddr = entry_addr(sp_r, i_r + FW'(1));
        if (dst != sp_r) begin
          st_waddr = entry_addr(new_bkt, newf_r);
          newf_nxt = newf_r + FW'(1);
        end else begin
          st_waddr = entry_addr(sp_r, keep_r);
          keep_nxt = keep_r + FW'(1);
        end
        if (i_r + FW'(1) == n_r) begin
          state_nxt = S_SEND;
        end else begin
          i_nxt = i_r + FW'(1);
        end
      end
      S_SEND: begin
        fill_we    = 1'b1;
        fill_waddr = sp_r;
        fill_wdata = keep_r;
        state_nxt  = S_SEND2;
      end
      S_SEND2: begin
        fill_we    = 1'b1;
        fill_waddr = new_bkt;
        fill_wdata = newf_r;
        if (HW'(sp_r) + HW'(1) == (mod_r >> 1)) begin
          sp_nxt = '0;
        end else begin
          sp_nxt = sp_r + BW'(1);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_if.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_key_nxt    = key_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      store_mem[st_waddr] <= st_wdata;
    end
    store_q <= store_mem[st_raddr];
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    fill_q <= fill_mem[fill_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT0;
      count_r     <= HW'(2);
      mod_r       <= HW'(2);
      sp_r        <= '0;
      total_r     <= '0;
      pcap_r      <= PAGE_CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      mod_r       <= mod_nxt;
      sp_r        <= sp_nxt;
      total_r     <= total_nxt;
      pcap_r      <= pcap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r        <= key_nxt;
    bucket_r     <= bucket_nxt;
    n_r          <= n_nxt;
    i_r          <= i_nxt;
    keep_r       <= keep_nxt;
    newf_r       <= newf_nxt;
    prod_r       <= prod_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
  end

endmodule

`default_nettype wire

// File: hw/rtl/lhs_checker.sv
// lhs_checker: port-level assertions for linear_hash_set_insert
// depends on lhs_pkg; bound to the top level at the end of this file
`default_nettype none

module lhs_checker
  import lhs_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [STATUS_W-1:0] out_status,
  input wire logic [KEY_W-1:0]    out_key_echo
);

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_key_echo))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_NEW || out_status == ST_DUP || out_status == ST_FULL))
    else $error("undefined status code");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

endmodule

bind linear_hash_set_insert lhs_checker u_lhs_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_if.valid),
  .in_ready     (in_if.ready),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .out_status   (out_if.status),
  .out_key_echo (out_if.key_echo)
);

`default_nettype wire

// File: test/lhs_checker.sv
// lhs_scoreboard: watches the key and result channels of linear_hash_set_insert,
// keeps its own copy of the hash table and compares every result; uses lhs_pkg
`default_nettype none

module lhs_scoreboard
  import lhs_pkg::*;
#(
  parameter int MAX_BUCKETS        = MAX_BUCKETS_DEF,
  parameter int ENTRIES_PER_BUCKET = ENTRIES_PER_BUCKET_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  lhs_in_if.sink                in_mon,
  lhs_out_if.sink               out_mon,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  output int                    fail_count,
  output int                    pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [KEY_W-1:0]    key;
  } insert_result_t;

  logic [KEY_W-1:0] slots [MAX_BUCKETS][ENTRIES_PER_BUCKET];
  int unsigned      fill [MAX_BUCKETS];
  int unsigned      n_buckets, modulus, split_ptr, n_stored;
  logic [CFG_W-1:0] page_cap;
  insert_result_t   expected_results [$];

  function automatic int unsigned bucket_of(logic [KEY_W-1:0] k);
    int unsigned b;
    b = k & (modulus - 1);
    if (b >= n_buckets) b -= modulus / 2;
    if (b >= MAX_BUCKETS) b = 0;
    return b;
  endfunction

  function automatic void split_one();
    int unsigned src, dst, nkeep, n;
    logic [KEY_W-1:0] kept [ENTRIES_PER_BUCKET];
    logic [KEY_W-1:0] k;
    src = split_ptr;
    if (src >= MAX_BUCKETS) src = 0;
    fill[n_buckets] = 0;
    n_buckets++;
    if (modulus < n_buckets) modulus *= 2;
    nkeep = 0;
    n = fill[src];
    for (int i = 0; i < n; i++) begin
      k = slots[src][i];
      dst = bucket_of(k);
      if (dst != src && fill[dst] < ENTRIES_PER_BUCKET) begin
        slots[dst][fill[dst]] = k;
        fill[dst]++;
      end else begin
        kept[nkeep] = k;
        nkeep++;
      end
    end
    for (int i = 0; i < nkeep; i++) slots[src][i] = kept[i];
    fill[src] = nkeep;
    split_ptr++;
    if (split_ptr == modulus / 2) split_ptr = 0;
  endfunction

  function automatic insert_result_t insert_key(logic [KEY_W-1:0] k);
    insert_result_t r;
    int unsigned b, n;
    longint unsigned lhs, rhs;
    b = bucket_of(k);
    n = fill[b];
    r.key = k;
    r.status = ST_NEW;
    for (int i = 0; i < n; i++)
      if (slots[b][i] == k) r.status = ST_DUP;
    if (r.status == ST_NEW) begin
      if (n >= ENTRIES_PER_BUCKET) begin
        r.status = ST_FULL;
      end else begin
        slots[b][n] = k;
        fill[b] = n + 1;
        n_stored++;
        lhs = longint'(n_stored) * 4;
        rhs = longint'(n_buckets) * page_cap * 3;
        if (lhs > rhs && n_buckets < MAX_BUCKETS) split_one();
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    insert_result_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < MAX_BUCKETS; i++) fill[i] = 0;
      n_buckets = 2;
      modulus = 2;
      split_ptr = 0;
      n_stored = 0;
      page_cap = PAGE_CAP_RESET;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) page_cap = cfg_wdata;
      if (in_mon.valid && in_mon.ready)
        expected_results.insert(expected_results.size(), insert_key(in_mon.key));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d key=%h", $time,
                   out_mon.status, out_mon.key_echo);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.status !== out_mon.status || exp_r.key !== out_mon.key_echo) begin
            $display("%0t: mismatch expected status=%0d key=%h, got status=%0d key=%h",
                     $time, exp_r.status, exp_r.key, out_mon.status, out_mon.key_echo);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending_count <= expected_results.size();
  end
endmodule

`default_nettype wire

// File: test/linear_hash_set_insert_tb.sv
// linear_hash_set_insert_tb: drives keys and page_capacity settings into the
// block with bursty input and stalling output; checking lives in lhs_scoreboard
`default_nettype none

module linear_hash_set_insert_tb
  import lhs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2_000_000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  int               fail_count, pending_count;
  int               cycle_count = 0;
  logic [KEY_W-1:0] key_pool [$];
  int               stall_phase = 0;

  lhs_in_if  in_if ();
  lhs_out_if out_if ();

  initial begin
    in_if.valid = 1'b0;
    in_if.key = '0;
    out_if.ready = 1'b0;
  end

  linear_hash_set_insert u_top (
    .clk(clk), .rst_n(rst_n), .in_if(in_if.sink), .out_if(out_if.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  lhs_scoreboard u_checker (
    .clk(clk), .rst_n(rst_n), .in_mon(in_if.sink), .out_mon(out_if.sink),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: long stall-free stretches, then a pattern of stalls
  always @(posedge clk) begin
    stall_phase <= (stall_phase + 1) % 400;
    if (stall_phase < 120) out_if.ready <= 1'b1;
    else if (stall_phase < 260) out_if.ready <= ($urandom_range(3) != 0);
    else out_if.ready <= ($urandom_range(2) == 0);
  end

  task automatic send_key(logic [KEY_W-1:0] k);
    in_if.valid <= 1'b1;
    in_if.key <= k;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    key_pool.insert(key_pool.size(), k);
  endtask

  task automatic idle_gap();
    int gap;
    gap = ($urandom_range(3) == 0) ? $urandom_range(20) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_page_cap(logic [CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] random_key();
    case ($urandom_range(5))
      0, 1: return key_pool.size() ? key_pool[$urandom_range(key_pool.size() - 1)]
                                   : $urandom();
      2: return {8'($urandom_range(255)), 24'h0} | 32'($urandom_range(63));
      3: return $urandom_range(4095);
      default: return $urandom();
    endcase
  endfunction

  // one phase: bursts of keys; narrow keys pile into few buckets to hit full
  task automatic run_phase(int n, bit narrow);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && n > 0) begin
        if (narrow) send_key(($urandom_range(3) == 0) ? random_key()
                             : 32'($urandom_range(255)) << 6);
        else send_key(random_key());
        burst--;
        n--;
      end
      idle_gap();
    end
  endtask

  logic [CFG_W-1:0] caps [6] = '{7'd30, 7'd1, 7'd64, 7'd0, 7'd127, 7'd7};

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes, duplicates, default capacity
    send_key(32'h0000_0000);
    send_key(32'hFFFF_FFFF);
    send_key(32'h8000_0000);
    send_key(32'h7FFF_FFFF);
    send_key(32'h0000_0001);
    send_key(32'hFFFF_FFFF);
    send_key(32'h0000_0000);
    send_key(32'hAAAA_AAAA);
    send_key(32'h5555_5555);
    send_key(32'h5555_5555);
    // a single bucket filled past capacity: full, then duplicate in a full bucket
    for (int i = 0; i < 72; i++) send_key(32'h0100_0000 * i);
    send_key(32'h0100_0000);
    drain();

    foreach (caps[p]) begin
      write_page_cap(caps[p]);
      run_phase(p == 3 ? 500 : 220, p == 1);
      drain();
    end

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

`default_nettype wire
